// File: rtl/fpu_pkg.sv
// Package: payload types and constants for the single-precision float unit.
package fpu_pkg;

  typedef enum logic [1:0] {
    OP_ENCODE = 2'd0,
    OP_MUL    = 2'd1,
    OP_ADD    = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  localparam logic [9:0]  EXP_BIAS      = 10'd127;
  localparam logic [9:0]  ENC_EXP_BASE  = 10'd95;
  localparam logic [31:0] SIGN_BIT      = 32'h8000_0000;
  localparam logic [23:0] HIDDEN        = 24'h80_0000;

  typedef struct packed {
    logic [1:0]         op;
    logic signed [31:0] int_part;
    logic [31:0]        frac_part;
    logic [31:0]        a_bits;
    logic [31:0]        b_bits;
  } in_t;

  typedef struct packed {
    logic [31:0] result_bits;
    logic        exponent_error;
  } out_t;

  // Position of leading one in a 64-bit word (0 when zero).
  function automatic logic [5:0] lead64(input logic [63:0] v);
    logic [5:0] p;
    p = 6'd0;
    for (int i = 0; i < 64; i++) begin
      if (v[i]) p = 6'(i);
    end
    return p;
  endfunction

  // Leading zeros above bit 23 of a 24-bit word (24 when zero).
  function automatic logic [4:0] lz24(input logic [23:0] v);
    logic [4:0] n;
    n = 5'd24;
    for (int i = 0; i < 24; i++) begin
      if (v[i]) n = 5'(23 - i);
    end
    return n;
  endfunction

  function automatic logic pack_err(input logic signed [10:0] e);
    return (e < 11'sd1) || (e > 11'sd254);
  endfunction

endpackage

// File: rtl/fpu_pipe.sv
// Module: three-stage datapath for encode, multiply and add.
module fpu_pipe (
  input  logic          clk,
  input  logic          rst,
  input  logic          adv,
  input  logic          in_vld,
  input  fpu_pkg::in_t  din,
  output logic          out_vld,
  output fpu_pkg::out_t dout
);
  import fpu_pkg::*;

  // Stage 1: decode, align, multiply, leading-one search
  logic        v1;
  logic [1:0]  op1;
  logic        zero1;
  logic [31:0] pass1;
  logic        sign1;
  logic signed [10:0] exp1;
  logic [63:0] encm1;
  logic [5:0]  encp1;
  logic [47:0] prod1;
  logic        sub1;
  logic [23:0] ma1;
  logic [23:0] mb1;
  logic        sa1;
  logic        sb1;

  logic [31:0] a;
  logic [31:0] b;
  logic [7:0]  ea;
  logic [7:0]  eb;
  logic [23:0] sma;
  logic [23:0] smb;
  logic [7:0]  dab;
  logic [7:0]  dba;
  logic [31:0] mag;
  logic [63:0] encm;
  logic        aza;
  logic        azb;

  always_comb begin
    a    = din.a_bits;
    b    = din.b_bits;
    ea   = a[30:23];
    eb   = b[30:23];
    sma  = {1'b1, a[22:0]};
    smb  = {1'b1, b[22:0]};
    dab  = ea - eb;
    dba  = eb - ea;
    aza  = (a[30:0] == 31'd0);
    azb  = (b[30:0] == 31'd0);
    mag  = din.int_part[31] ? (32'd0 - din.int_part) : din.int_part;
    encm = {mag, din.frac_part};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= in_vld;
    end
    if (adv) begin
      op1   <= din.op;
      encm1 <= encm;
      encp1 <= lead64(encm);
      prod1 <= sma * smb;
      sa1   <= a[31];
      sb1   <= b[31];
      sub1  <= a[31] ^ b[31];
      pass1 <= 32'd0;
      zero1 <= 1'b0;
      sign1 <= 1'b0;
      exp1  <= 11'sd0;
      ma1   <= sma;
      mb1   <= smb;
      case (din.op)
        OP_ENCODE: begin
          sign1 <= din.int_part[31];
          zero1 <= (mag[30:0] == 31'd0) && (din.frac_part == 32'd0);
        end
        OP_MUL: begin
          sign1 <= a[31] ^ b[31];
          zero1 <= aza || azb;
          exp1  <= 11'(signed'({3'b0, ea})) + 11'(signed'({3'b0, eb}))
                   - 11'(signed'({1'b0, EXP_BIAS}));
        end
        OP_ADD: begin
          zero1 <= aza || azb;
          pass1 <= (aza && azb) ? 32'd0 : (aza ? b : a);
          if (ea >= eb) begin
            exp1 <= 11'(signed'({3'b0, ea}));
            mb1  <= (dab >= 8'd32) ? 24'd0 : (smb >> dab);
          end else begin
            exp1 <= 11'(signed'({3'b0, eb}));
            ma1  <= (dba >= 8'd32) ? 24'd0 : (sma >> dba);
          end
        end
        default: begin
          zero1 <= 1'b1;
        end
      endcase
    end
  end

  // Stage 2: add/subtract, encode shift, multiply normalize
  logic        v2;
  logic [1:0]  op2;
  logic        zero2;
  logic [31:0] pass2;
  logic        sign2;
  logic signed [10:0] exp2;
  logic [24:0] m2;
  logic [4:0]  lz2;
  logic [22:0] mant2;

  logic [24:0] sum;
  logic [23:0] dif;
  logic [63:0] encs;

  always_comb begin
    sum  = {1'b0, ma1} + {1'b0, mb1};
    dif  = (ma1 > mb1) ? (ma1 - mb1) : (mb1 - ma1);
    encs = encm1 << (6'd63 - encp1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv) begin
      v2 <= v1;
    end
    if (adv) begin
      op2   <= op1;
      pass2 <= zero1 ? pass1 : 32'd0;
      zero2 <= zero1;
      sign2 <= sign1;
      exp2  <= exp1;
      m2    <= 25'd0;
      lz2   <= 5'd0;
      mant2 <= 23'd0;
      case (op1)
        OP_ENCODE: begin
          exp2  <= 11'(signed'({1'b0, ENC_EXP_BASE})) + 11'(signed'({5'b0, encp1}));
          mant2 <= encs[62:40];
        end
        OP_MUL: begin
          if (prod1[47]) begin
            exp2  <= exp1 + 11'sd1;
            mant2 <= prod1[46:24];
          end else begin
            mant2 <= prod1[45:23];
          end
        end
        OP_ADD: begin
          if (!sub1) begin
            sign2 <= sa1;
            m2    <= sum;
          end else begin
            sign2 <= (ma1 > mb1) ? sa1 : sb1;
            m2    <= {1'b0, dif};
            lz2   <= lz24(dif);
            if (ma1 == mb1) zero2 <= 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Stage 3: add normalize and pack
  logic [31:0] r3;
  logic        e3;
  logic signed [10:0] ex;
  logic [22:0] mn;
  logic [31:0] pk;
  logic [23:0] sh;

  always_comb begin
    ex = exp2;
    mn = mant2;
    sh = m2[23:0] << lz2;
    if (op2 == OP_ADD) begin
      if (m2[24]) begin
        ex = exp2 + 11'sd1;
        mn = m2[23:1];
      end else begin
        ex = exp2 - 11'(signed'({6'b0, lz2}));
        mn = sh[22:0];
      end
    end
    pk = {sign2, ex[7:0], mn};
    r3 = pk;
    e3 = pack_err(ex);
    if (zero2) begin
      r3 = (op2 == OP_ADD) ? pass2 : 32'd0;
      e3 = 1'b0;
    end else if (op2 == OP_ADD && pk == SIGN_BIT) begin
      r3 = 32'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (adv) begin
      out_vld <= v2;
    end
    if (adv) begin
      dout.result_bits    <= r3;
      dout.exponent_error <= e3;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst && v2 && op2 == OP_ENCODE && !zero2) begin
      assert (!pack_err(exp2)) else $error("encode exponent out of range");
    end
  end

  a_none_zero: assert property (@(posedge clk) disable iff (rst)
    (adv && v1 && op1 == OP_NONE) |=> zero2);
  a_mul_prod: assert property (@(posedge clk) disable iff (rst)
    (v1 && op1 == OP_MUL && !zero1) |-> (prod1[47] || prod1[46]));
  a_vld_flow: assert property (@(posedge clk) disable iff (rst)
    adv |=> (out_vld == $past(v2)));
endmodule

// File: rtl/float32_encode_mul_add_unit.sv
// Top level: pipelined single-precision encode, multiply and add unit.
// Accepts one transaction per cycle unless the pipe is stalled; each result
// is offered after passing three register stages (align and multiply, add and
// shift, normalise and pack, the last being the output register). The output
// stage stalls the whole pipe when the result is not taken, so in_ready
// follows out_ready or an empty slot.
module float32_encode_mul_add_unit (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  fpu_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output fpu_pkg::out_t out_data
);
  import fpu_pkg::*;

  logic adv;

  assign adv      = out_ready || !out_valid;
  assign in_ready = adv;

  fpu_pipe u_pipe (
    .clk     (clk),
    .rst     (rst),
    .adv     (adv),
    .in_vld  (in_valid),
    .din     (in_data),
    .out_vld (out_valid),
    .dout    (out_data)
  );

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)));
  a_rdy: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready);
  a_clear: assert property (@(posedge clk) rst |=> !out_valid);
endmodule
